// ----- design/rabe_pkg.sv -----
`default_nettype none

package rabe_pkg;

    localparam int NUM_REGS   = 32;
    localparam int PROG_DEPTH = 256;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int PC_W       = 8;
    localparam int DATA_W     = 32;

    // stream widths
    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 3;

    typedef enum logic [3:0] {
        KIND_ADD  = 4'd0,
        KIND_ADDI = 4'd1,
        KIND_SUB  = 4'd2,
        KIND_MULT = 4'd3,
        KIND_DIV  = 4'd4,
        KIND_B    = 4'd5,
        KIND_BEQ  = 4'd6,
        KIND_BNQ  = 4'd7,
        KIND_LOAD = 4'd8,
        KIND_READ = 4'd9
    } rabe_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_DFIX,
        ST_DONE
    } rabe_state_t;

endpackage

`default_nettype wire

// ----- design/register_alu_branch_executor.sv -----
`default_nettype none
// Path from input transfer to result valid: register file read, then commit for most kinds;
//   div adds 32 radix-2 divider steps and a sign fix between the read and the commit.
// One item at a time; a div item is held longest, by the iterative divider.
// The next item is taken while a result still waits in the output register.
// Reset (aresetn low, synchronous): registers read as zero, pc is zero, no result pending.
module register_alu_branch_executor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // dest_index[4:0], src_a_index[9:5], src_b_index[14:10], immediate[46:15],
    // branch_target[54:47], zero[55]
    input  logic [rabe_pkg::S_DATA_W-1:0] s_tdata,
    // kind[3:0]
    input  logic [rabe_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc[7:0], value[39:8]
    output logic [rabe_pkg::M_DATA_W-1:0] m_tdata,
    // wrote_register[0], branch_taken[1], divide_error[2]
    output logic [rabe_pkg::M_USER_W-1:0] m_tuser
);
    import rabe_pkg::*;

    // ---------------------------------------------------------------
    // Control and latched item fields
    // ---------------------------------------------------------------
    rabe_state_t state_reg, state_next;

    rabe_kind_t            kind_reg;
    logic [REG_IDX_W-1:0]  dest_reg;
    logic [DATA_W-1:0]     imm_reg;
    logic [PC_W-1:0]       target_reg;
    logic [PC_W-1:0]       pc_reg;

    logic s_fire;
    logic done_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Result registers and divider state
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              res_wrote_reg, res_wrote_next;
    logic              res_taken_reg, res_taken_next;
    logic              res_derr_reg,  res_derr_next;

    logic [DATA_W:0]   rem_reg, rem_next;     // partial remainder, one guard bit
    logic [DATA_W-1:0] quo_reg, quo_next;     // dividend shifts out, quotient shifts in
    logic [DATA_W-1:0] dvs_reg, dvs_next;     // divisor magnitude
    logic              neg_reg, neg_next;     // quotient sign
    logic [4:0]        cnt_reg, cnt_next;

    // ---------------------------------------------------------------
    // Register file: two synchronous read ports, one write port.
    // Valid bits stand in for the all-zero reset; an unwritten entry reads zero.
    // Writes only land in ST_DONE and the next read is issued in ST_IDLE,
    // so a read never overlaps a pending write to the same entry.
    // ---------------------------------------------------------------
    logic [DATA_W-1:0]    mem [NUM_REGS];
    logic [NUM_REGS-1:0]  vld_reg;
    logic [REG_IDX_W-1:0] rd_addr_a;
    logic [REG_IDX_W-1:0] rd_addr_b;
    logic [DATA_W-1:0]    rd_a_reg;
    logic [DATA_W-1:0]    rd_b_reg;
    logic                 rd_a_vld_reg;
    logic                 rd_b_vld_reg;
    logic [DATA_W-1:0]    opa;
    logic [DATA_W-1:0]    opb;
    logic                 wr_en;

    // NUM_REGS is a power of two: index reduction is a part-select.
    // The read kind looks up dest_index on port A.
    assign rd_addr_a = (s_tuser == KIND_READ) ? s_tdata[REG_IDX_W-1:0]
                                               : s_tdata[5 +: REG_IDX_W];
    assign rd_addr_b = s_tdata[10 +: REG_IDX_W];

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
        if (wr_en) begin
            mem[dest_reg] <= res_value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            rd_a_vld_reg <= 1'b0;
            rd_b_vld_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                rd_a_vld_reg <= vld_reg[rd_addr_a];
                rd_b_vld_reg <= vld_reg[rd_addr_b];
            end
            if (wr_en) begin
                vld_reg[dest_reg] <= 1'b1;
            end
        end
    end

    assign opa = rd_a_vld_reg ? rd_a_reg : '0;
    assign opb = rd_b_vld_reg ? rd_b_reg : '0;

    logic [2*DATA_W-1:0] prod_full;
    logic [DATA_W:0]     rem_sh;
    logic [DATA_W:0]     rem_diff;
    logic [PC_W-1:0]     pc_next;

    assign prod_full = opa * opb;
    assign rem_sh    = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
    assign rem_diff  = rem_sh - {1'b0, dvs_reg};

    // PROG_DEPTH equals 2**PC_W: the increment wraps on its own.
    assign pc_next = res_taken_reg ? target_reg : pc_reg + PC_W'(1);

    // commit once the output register is free or being drained
    assign done_fire = (state_reg == ST_DONE) && (!m_tvalid || m_tready);
    assign wr_en     = done_fire && res_wrote_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (done_fire) begin
                pc_reg <= pc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg   <= rabe_kind_t'(s_tuser);
            dest_reg   <= s_tdata[REG_IDX_W-1:0];
            imm_reg    <= s_tdata[15 +: DATA_W];
            target_reg <= s_tdata[47 +: PC_W];
        end
        res_value_reg <= res_value_next;
        res_wrote_reg <= res_wrote_next;
        res_taken_reg <= res_taken_next;
        res_derr_reg  <= res_derr_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
    end

    always_comb begin
        state_next     = state_reg;
        res_value_next = res_value_reg;
        res_wrote_next = res_wrote_reg;
        res_taken_next = res_taken_reg;
        res_derr_next  = res_derr_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // operands have arrived from the register file
                res_value_next = '0;
                res_wrote_next = 1'b0;
                res_taken_next = 1'b0;
                res_derr_next  = 1'b0;
                state_next     = ST_DONE;
                unique case (kind_reg)
                    KIND_ADD: begin
                        res_value_next = opa + opb;
                        res_wrote_next = 1'b1;
                    end
                    KIND_ADDI: begin
                        res_value_next = opa + imm_reg;
                        res_wrote_next = 1'b1;
                    end
                    KIND_SUB: begin
                        res_value_next = opa - opb;
                        res_wrote_next = 1'b1;
                    end
                    KIND_MULT: begin
                        res_value_next = prod_full[DATA_W-1:0];
                        res_wrote_next = 1'b1;
                    end
                    KIND_DIV: begin
                        if (opb == '0) begin
                            res_derr_next = 1'b1;
                        end else begin
                            neg_next   = opa[DATA_W-1] ^ opb[DATA_W-1];
                            quo_next   = opa[DATA_W-1] ? -opa : opa;
                            dvs_next   = opb[DATA_W-1] ? -opb : opb;
                            rem_next   = '0;
                            cnt_next   = '1;
                            state_next = ST_DIV;
                        end
                    end
                    KIND_B: begin
                        res_taken_next = 1'b1;
                    end
                    KIND_BEQ: begin
                        res_taken_next = (opa == opb);
                    end
                    KIND_BNQ: begin
                        res_taken_next = (opa != opb);
                    end
                    KIND_LOAD: begin
                        res_value_next = imm_reg;
                        res_wrote_next = 1'b1;
                    end
                    KIND_READ: begin
                        res_value_next = opa;
                    end
                    default: begin
                        // unused kinds: pc advances, nothing else
                    end
                endcase
            end
            ST_DIV: begin
                // restoring radix-2 step on magnitudes
                if (!rem_diff[DATA_W]) begin
                    rem_next = rem_diff;
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    state_next = ST_DFIX;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_DFIX: begin
                // truncation toward zero; most-negative / -1 wraps naturally
                res_value_next = neg_reg ? -quo_reg : quo_reg;
                res_wrote_next = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (done_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Output register: holds a result until its transfer completes
    // ---------------------------------------------------------------
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_fire) begin
            m_data_reg <= {res_value_reg, pc_next};
            m_user_reg <= {res_derr_reg, res_taken_reg, res_wrote_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- design/rabe_checker.sv -----
`default_nettype none

module rabe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rabe_pkg::S_DATA_W-1:0] s_tdata,
    input logic [rabe_pkg::S_USER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rabe_pkg::M_DATA_W-1:0] m_tdata,
    input logic [rabe_pkg::M_USER_W-1:0] m_tuser
);
    import rabe_pkg::*;

    // stalled result keeps valid
    a_m_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // stalled result keeps its payload
    a_m_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // one item in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a register write and a taken branch never come together
    a_write_xor_branch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("write and branch in one result");

    // divide error writes nothing and reports zero
    a_derr_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> !m_tuser[0] && !m_tuser[1] && (m_tdata[39:8] == '0))
        else $error("divide error result not clean");

endmodule

bind register_alu_branch_executor rabe_checker u_rabe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
